// ===== hdl/lmdp_pkg.sv =====
// Shared constants, widths and a helper function for the table-based dot-product engine.
package lmdp_pkg;

    // Operand and table geometry
    localparam int OP_W      = 16;
    localparam int MAG_W     = 8;
    localparam int ADDR_W    = 2 * MAG_W;
    localparam int TBL_DEPTH = 1 << ADDR_W;
    localparam int ENTRY_W   = 17;
    localparam longint unsigned ENTRY_MAX = (64'd1 << ENTRY_W) - 64'd1;

    // Default parameter values
    localparam int MAX_TERMS_DEF = 4096;
    localparam int MAG_LIMIT_DEF = 255;

    // Input stream layout, lowest field first
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + MAG_W;
    localparam int VAL_LSB    = COL_LSB + MAG_W;
    localparam int WGT_LSB    = VAL_LSB + ENTRY_W;
    localparam int ACT_LSB    = WGT_LSB + OP_W;
    localparam int S_FIELDS_W = ACT_LSB + OP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 1;

    // Output stream layout
    localparam int RES_W     = 11;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Scaling: the sum is divided by one million as a shift by 64 and a
    // divide by 15625.
    localparam int PRE_SHIFT = 6;
    localparam int DIV_REST  = 15625;
    localparam int DIV_LOG2  = 14;
    localparam int QUO_W     = 12;
    localparam int RES_MAX   = 1023;
    localparam int RES_MIN_MAG = 1024;

    // Item kinds carried on the input side channel
    typedef enum logic [S_TUSER_W-1:0] {
        ACT_WRITE = 1'b0,
        ACT_ACCUM = 1'b1
    } t_action;

    // Clamp a signed operand to +-lim and return its magnitude.
    function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [OP_W-1:0] v,
                                                   input logic [MAG_W-1:0] lim);
        logic signed [OP_W:0] ext;
        logic signed [OP_W:0] lim_ext;
        logic signed [OP_W:0] neg_ext;
        ext     = $signed({v[OP_W-1], v});
        lim_ext = $signed((OP_W + 1)'(lim));
        neg_ext = -ext;
        if (ext > lim_ext || ext < -lim_ext) begin
            return lim;
        end else if (ext < 0) begin
            return neg_ext[MAG_W-1:0];
        end else begin
            return ext[MAG_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/lmdp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module lmdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lut_multiplier_dot_product.sv =====
// Top level of the table-based dot-product engine.
//
// The multiplier of this dot-product engine is a 256 x 256 table of 17-bit
// product magnitudes held in a synchronous RAM. A transfer with tuser set to
// write stores one entry; a transfer with tuser set to accumulate clamps the
// weight and the activation to +-MAG_LIMIT, reads the entry at their two
// magnitudes and adds or subtracts it from a saturating running sum. A term
// with tlast set ends the dot product: the sum is divided by one million,
// truncated toward zero, saturated to -1024..1023 and sent as one output
// transfer, and the sum restarts from zero. The engine takes one transfer
// per cycle, writes and accumulates freely mixed; the registered table read
// followed by the add into the running sum is the loop that sets that rate.
// After its last term is taken, a result leaves through the term register, a
// three-stage reciprocal-multiply divider and an output register. Input
// stalls only when a last term meets a full divider under output
// backpressure. The table has no reset and no clearing pass: every entry
// must be written before a term reads it.
module lut_multiplier_dot_product
    import lmdp_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int MAG_LIMIT = MAG_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // table_row, table_col, table_value, weight_scaled, activation_scaled, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [S_TUSER_W-1:0] s_tuser,
    // last_term
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dot_result, zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Sum and divider sizing follow from the term count.
    localparam longint unsigned SUM_LIM = longint'(MAX_TERMS) * ENTRY_MAX;
    localparam int SUM_W  = $clog2(SUM_LIM + 1) + 1;
    localparam int SMAG_W = SUM_W - 1;
    localparam int X_W    = SMAG_W - PRE_SHIFT;
    localparam int K      = X_W + DIV_LOG2;
    localparam int M_W    = X_W + 1;
    localparam int P_W    = X_W + M_W;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << K) + 64'(DIV_REST) - 64'd1) / 64'(DIV_REST));
    localparam logic signed [SUM_W:0] LIM_S = $signed((SUM_W + 1)'(SUM_LIM));

    // Input fields
    logic [MAG_W-1:0]       s_row;
    logic [MAG_W-1:0]       s_col;
    logic [ENTRY_W-1:0]     s_value;
    logic signed [OP_W-1:0] s_wgt;
    logic signed [OP_W-1:0] s_act;
    logic [MAG_W-1:0]       s_wgt_mag;
    logic [MAG_W-1:0]       s_act_mag;
    logic                   s_accept;
    logic                   s_is_acc;

    // Accumulate stage
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic                   r_s1_neg;
    logic                   r_s1_zero;
    logic [ENTRY_W-1:0]     tbl_rd_data;
    logic [ENTRY_W-1:0]     s1_entry;
    logic signed [SUM_W:0]  s1_term;
    logic signed [SUM_W:0]  s1_raw;
    logic signed [SUM_W-1:0] s1_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic                   s1_block;
    logic                   s1_fire;

    // Divider and output stages
    logic                   r_d1_valid;
    logic signed [SUM_W-1:0] r_d1_sum;
    logic [SUM_W-1:0]       d1_neg_sum;
    logic                   r_d2_valid;
    logic                   r_d2_neg;
    logic [X_W-1:0]         r_d2_x;
    logic                   r_d3_valid;
    logic                   r_d3_neg;
    logic [P_W-1:0]         r_d3_prod;
    logic [QUO_W-1:0]       d3_quo;
    logic [QUO_W-1:0]       d3_res;
    logic                   r_out_valid;
    logic [RES_W-1:0]       r_out_data;
    logic                   out_ready;
    logic                   d3_ready;
    logic                   d2_ready;
    logic                   d1_ready;

    // Field unpacking and operand clamping.
    assign s_row     = s_tdata[ROW_LSB +: MAG_W];
    assign s_col     = s_tdata[COL_LSB +: MAG_W];
    assign s_value   = s_tdata[VAL_LSB +: ENTRY_W];
    assign s_wgt     = $signed(s_tdata[WGT_LSB +: OP_W]);
    assign s_act     = $signed(s_tdata[ACT_LSB +: OP_W]);
    assign s_wgt_mag = clamp_mag(s_wgt, MAG_W'(MAG_LIMIT));
    assign s_act_mag = clamp_mag(s_act, MAG_W'(MAG_LIMIT));

    // Handshake: only a last term waiting on a full divider holds the input.
    assign out_ready = !r_out_valid || m_tready;
    assign d3_ready  = !r_d3_valid || out_ready;
    assign d2_ready  = !r_d2_valid || d3_ready;
    assign d1_ready  = !r_d1_valid || d2_ready;
    assign s1_block  = r_s1_valid && r_s1_last && !d1_ready;
    assign s1_fire   = r_s1_valid && !s1_block;
    assign s_tready  = !s1_block;
    assign s_accept  = s_tvalid && s_tready;
    assign s_is_acc  = (t_action'(s_tuser) == ACT_ACCUM);

    // Product table: writes store entries, accumulate terms read them.
    lmdp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (s_accept && !s_is_acc),
        .i_wr_addr ({s_row, s_col}),
        .i_wr_data (s_value),
        .i_rd_en   (s_accept && s_is_acc),
        .i_rd_addr ({s_wgt_mag, s_act_mag}),
        .o_rd_data (tbl_rd_data)
    );

    // Term control travels beside the table read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept && s_is_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && s_is_acc) begin
            r_s1_last <= s_tlast;
            r_s1_neg  <= s_wgt[OP_W-1] ^ s_act[OP_W-1];
            r_s1_zero <= (s_wgt == '0) || (s_act == '0);
        end
    end

    // Signed add of the table entry with saturation at the sum limit.
    always_comb begin
        s1_entry = r_s1_zero ? '0 : tbl_rd_data;
        s1_term  = $signed((SUM_W + 1)'(s1_entry));
        s1_raw   = $signed({r_sum[SUM_W-1], r_sum}) + (r_s1_neg ? -s1_term : s1_term);
        if (s1_raw > LIM_S) begin
            s1_sum = SUM_W'(LIM_S);
        end else if (s1_raw < -LIM_S) begin
            s1_sum = SUM_W'(-LIM_S);
        end else begin
            s1_sum = SUM_W'(s1_raw);
        end
    end

    // Running sum restarts after a last term.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (s1_fire) begin
            r_sum <= r_s1_last ? '0 : s1_sum;
        end
    end

    // Divider stage 1: hold the finished sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_d1_valid <= 1'b1;
        end else if (d2_ready) begin
            r_d1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_d1_sum <= s1_sum;
        end
    end

    // Divider stage 2: sign and magnitude, pre-divided by 64.
    assign d1_neg_sum = SUM_W'(-r_d1_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_valid <= 1'b0;
        end else if (d2_ready) begin
            r_d2_valid <= r_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d1_valid && d2_ready) begin
            r_d2_neg <= r_d1_sum[SUM_W-1];
            r_d2_x   <= r_d1_sum[SUM_W-1] ? d1_neg_sum[SMAG_W-1:PRE_SHIFT]
                                          : r_d1_sum[SMAG_W-1:PRE_SHIFT];
        end
    end

    // Divider stage 3: multiply by the reciprocal of 15625.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3_valid <= 1'b0;
        end else if (d3_ready) begin
            r_d3_valid <= r_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d2_valid && d3_ready) begin
            r_d3_neg  <= r_d2_neg;
            r_d3_prod <= P_W'(r_d2_x) * P_W'(RECIP);
        end
    end

    // Quotient, sign and saturation to the result range.
    always_comb begin
        d3_quo = QUO_W'(r_d3_prod >> K);
        if (r_d3_neg) begin
            d3_res = (d3_quo > QUO_W'(RES_MIN_MAG)) ? -QUO_W'(RES_MIN_MAG) : -d3_quo;
        end else begin
            d3_res = (d3_quo > QUO_W'(RES_MAX)) ? QUO_W'(RES_MAX) : d3_quo;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d3_valid && out_ready) begin
            r_out_data <= d3_res[RES_W-1:0];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_TDATA_W'(r_out_data);

`ifndef ASSERT_OFF
    // The running sum never leaves the saturation window.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed({r_sum[SUM_W-1], r_sum}) <= LIM_S) && ($signed({r_sum[SUM_W-1], r_sum}) >= -LIM_S))
        else $error("running sum outside saturation window");

    // A last term leaves the running sum at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=> (r_sum == '0))
        else $error("running sum not cleared after last term");

    // The input stalls only for a waiting last term.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_s1_valid && r_s1_last && r_d1_valid))
        else $error("input stalled without a blocked last term");

    // A stalled term keeps its table data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> $stable(tbl_rd_data))
        else $error("table data lost under stall");
`endif

endmodule
